// ===== design/x86enc_pkg.sv =====
// x86enc_pkg: shared types and operation codes of the x86-64 instruction encoder
// no dependencies; used by the encode logic, the top level and the testbench

package x86enc_pkg;

  localparam int MaxBytes = 10;

  typedef logic [5:0] cmd_t;
  typedef logic [3:0] count_t;
  typedef logic [3:0] idx_t;

  // encoded instruction: bytes in emit order and their number
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    count_t                   count;
  } enc_t;

  localparam cmd_t CMD_PUSH          = 6'd0;
  localparam cmd_t CMD_PUSH_F        = 6'd1;
  localparam cmd_t CMD_PUSH_IMM      = 6'd2;
  localparam cmd_t CMD_POP           = 6'd3;
  localparam cmd_t CMD_POP_NUM       = 6'd4;
  localparam cmd_t CMD_POP_F         = 6'd5;
  localparam cmd_t CMD_MOV_RR        = 6'd6;
  localparam cmd_t CMD_MOV_RR_ND     = 6'd7;
  localparam cmd_t CMD_MOV_RR_NS     = 6'd8;
  localparam cmd_t CMD_MOV_ABS_ST    = 6'd9;
  localparam cmd_t CMD_MOV_ABS_LD    = 6'd10;
  localparam cmd_t CMD_LD_IND        = 6'd11;
  localparam cmd_t CMD_ST_AUTO       = 6'd12;
  localparam cmd_t CMD_ST_AUTO_NUM   = 6'd13;
  localparam cmd_t CMD_ST8           = 6'd14;
  localparam cmd_t CMD_ST8_NUM       = 6'd15;
  localparam cmd_t CMD_ST32          = 6'd16;
  localparam cmd_t CMD_ST32_NUM      = 6'd17;
  localparam cmd_t CMD_LD_AUTO       = 6'd18;
  localparam cmd_t CMD_LD8           = 6'd19;
  localparam cmd_t CMD_LD32          = 6'd20;
  localparam cmd_t CMD_MOV_IMM       = 6'd21;
  localparam cmd_t CMD_MOV_IMM_NUM   = 6'd22;
  localparam cmd_t CMD_MOV_IMM64     = 6'd23;
  localparam cmd_t CMD_MOV_IMM64_NUM = 6'd24;
  localparam cmd_t CMD_LD_F          = 6'd25;
  localparam cmd_t CMD_ST_F_AUTO     = 6'd26;
  localparam cmd_t CMD_ST_F8         = 6'd27;
  localparam cmd_t CMD_ST_F32        = 6'd28;
  localparam cmd_t CMD_CALL_REG      = 6'd29;
  localparam cmd_t CMD_CALL          = 6'd30;
  localparam cmd_t CMD_RET           = 6'd31;
  localparam cmd_t CMD_ADD_RR        = 6'd32;
  localparam cmd_t CMD_ADD_AUTO      = 6'd33;
  localparam cmd_t CMD_ADD8          = 6'd34;
  localparam cmd_t CMD_ADD32         = 6'd35;
  localparam cmd_t CMD_SUB_RR        = 6'd36;
  localparam cmd_t CMD_SUB8          = 6'd37;
  localparam cmd_t CMD_SUB32         = 6'd38;
  localparam cmd_t CMD_IMUL          = 6'd39;
  localparam cmd_t CMD_IDIV          = 6'd40;
  localparam cmd_t CMD_AND           = 6'd41;
  localparam cmd_t CMD_OR            = 6'd42;
  localparam cmd_t CMD_XOR           = 6'd43;
  localparam cmd_t CMD_NOT           = 6'd44;
  localparam cmd_t CMD_CMP           = 6'd45;
  localparam cmd_t CMD_JMP           = 6'd46;
  localparam cmd_t CMD_JE            = 6'd47;
  localparam cmd_t CMD_JNE           = 6'd48;
  localparam cmd_t CMD_JG            = 6'd49;
  localparam cmd_t CMD_JA            = 6'd50;
  localparam cmd_t CMD_JGE           = 6'd51;
  localparam cmd_t CMD_JAE           = 6'd52;
  localparam cmd_t CMD_JL            = 6'd53;
  localparam cmd_t CMD_JB            = 6'd54;
  localparam cmd_t CMD_JLE           = 6'd55;
  localparam cmd_t CMD_JBE           = 6'd56;

  localparam logic [2:0] RegAx = 3'd0;
  localparam logic [2:0] RegSp = 3'd4;
  localparam logic [2:0] RegBp = 3'd5;

endpackage

// ===== design/x86enc_if.sv =====
// x86enc request and code byte channels: valid/ready handshake with payload
// depends on x86enc_pkg for nothing but kept next to it in compile order

interface x86enc_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cmd;
  logic [2:0]  first_reg;
  logic [2:0]  second_reg;
  logic        narrow;
  logic signed [63:0] immediate;
  modport source (output valid, cmd, first_reg, second_reg, narrow, immediate, input ready);
  modport sink (input valid, cmd, first_reg, second_reg, narrow, immediate, output ready);
endinterface

interface x86enc_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;
  modport source (output valid, code_byte, last, input ready);
  modport sink (input valid, code_byte, last, output ready);
endinterface

// ===== design/x86enc_encode.sv =====
// x86enc_encode: combinational encoder, one request to up to ten code bytes
// depends on x86enc_pkg

module x86enc_encode (
  input  logic [5:0]  cmd,
  input  logic [2:0]  first_reg,
  input  logic [2:0]  second_reg,
  input  logic        narrow,
  input  logic [63:0] immediate,
  output x86enc_pkg::enc_t enc
);

  function automatic x86enc_pkg::enc_t put8(x86enc_pkg::enc_t e, logic [7:0] v);
    x86enc_pkg::enc_t r;
    r = e;
    if (r.count < 4'(x86enc_pkg::MaxBytes)) begin
      r.bytes[r.count] = v;
      r.count = r.count + 4'd1;
    end
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t put32(x86enc_pkg::enc_t e, logic [63:0] v);
    x86enc_pkg::enc_t r;
    r = put8(e, v[7:0]);
    r = put8(r, v[15:8]);
    r = put8(r, v[23:16]);
    r = put8(r, v[31:24]);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t put64(x86enc_pkg::enc_t e, logic [63:0] v);
    x86enc_pkg::enc_t r;
    r = put32(e, v);
    r = put32(r, {32'd0, v[63:32]});
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t wide(x86enc_pkg::enc_t e, logic nr);
    return nr ? e : put8(e, 8'h48);
  endfunction

  function automatic x86enc_pkg::enc_t reg_reg(x86enc_pkg::enc_t e, logic nr, logic [7:0] op,
                                               logic [2:0] rm, logic [2:0] rg);
    x86enc_pkg::enc_t r;
    r = wide(e, nr);
    r = put8(r, op);
    r = put8(r, {2'b11, rg, rm});
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t st_char_gp(x86enc_pkg::enc_t e, logic [2:0] base,
                                                  logic [63:0] off, logic [2:0] src, logic nr);
    x86enc_pkg::enc_t r;
    r = wide(e, nr);
    r = put8(r, 8'h89);
    if (base != x86enc_pkg::RegSp) begin
      r = put8(r, {2'b01, src, base});
    end else begin
      r = put8(r, {2'b01, src, 3'b100});
      r = put8(r, 8'h24);
    end
    r = put8(r, off[7:0]);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t st_char_num(x86enc_pkg::enc_t e, logic [2:0] base,
                                                   logic [63:0] off, logic [2:0] src);
    x86enc_pkg::enc_t r;
    r = put8(e, 8'h4c);
    r = put8(r, 8'h89);
    r = put8(r, {2'b01, src, base});
    r = put8(r, off[7:0]);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t st_int_any(x86enc_pkg::enc_t e, logic [7:0] pre,
                                                  logic use_pre, logic [2:0] base,
                                                  logic [63:0] off, logic [2:0] src);
    x86enc_pkg::enc_t r;
    r = use_pre ? put8(e, pre) : e;
    r = put8(r, 8'h89);
    if (base != x86enc_pkg::RegSp) begin
      r = put8(r, {2'b10, src, base});
    end else begin
      r = put8(r, {2'b10, src, 3'b100});
      r = put8(r, 8'h24);
    end
    r = put32(r, off);
    return r;
  endfunction

  // shared by the offset load and the float store: prefix bytes given by caller
  function automatic x86enc_pkg::enc_t mem_off(x86enc_pkg::enc_t e, logic [2:0] rg,
                                               logic [2:0] base, logic [63:0] off,
                                               logic is_int);
    x86enc_pkg::enc_t r;
    logic [1:0] md;
    md = is_int ? 2'b10 : 2'b01;
    if (base != x86enc_pkg::RegSp) begin
      r = put8(e, {md, rg, base});
    end else begin
      r = put8(e, {md, rg, 3'b100});
      r = put8(r, 8'h24);
    end
    r = is_int ? put32(r, off) : put8(r, off[7:0]);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t ld_off(x86enc_pkg::enc_t e, logic [2:0] dest,
                                              logic [2:0] base, logic [63:0] off,
                                              logic is_int);
    x86enc_pkg::enc_t r;
    r = put8(e, 8'h48);
    r = put8(r, 8'h8b);
    r = mem_off(r, dest, base, off, is_int);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t st_float(x86enc_pkg::enc_t e, logic [2:0] base,
                                                logic [63:0] off, logic [2:0] src,
                                                logic is_int);
    x86enc_pkg::enc_t r;
    r = put8(e, 8'hf3);
    r = put8(r, 8'h0f);
    r = put8(r, 8'h11);
    r = mem_off(r, src, base, off, is_int);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t ld_float(x86enc_pkg::enc_t e, logic [2:0] dest,
                                                logic [2:0] base);
    x86enc_pkg::enc_t r;
    r = put8(e, 8'hf3);
    r = put8(r, 8'h0f);
    r = put8(r, 8'h10);
    if (base == x86enc_pkg::RegSp) begin
      r = put8(r, {2'b00, dest, 3'b100});
      r = put8(r, 8'h24);
    end else if (base == x86enc_pkg::RegBp) begin
      r = put8(r, {2'b01, dest, 3'b101});
      r = put8(r, 8'h00);
    end else begin
      r = put8(r, {2'b00, dest, base});
    end
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t alu_byte(x86enc_pkg::enc_t e, logic [7:0] ext,
                                                logic [2:0] dest, logic [63:0] v, logic nr);
    x86enc_pkg::enc_t r;
    r = wide(e, nr);
    r = put8(r, 8'h83);
    r = put8(r, ext | {5'd0, dest});
    r = put8(r, v[7:0]);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t alu_int(x86enc_pkg::enc_t e, logic [7:0] ext,
                                               logic [7:0] short_op, logic [2:0] dest,
                                               logic [63:0] v, logic nr);
    x86enc_pkg::enc_t r;
    r = wide(e, nr);
    if (dest == x86enc_pkg::RegAx) begin
      r = put8(r, short_op);
    end else begin
      r = put8(r, 8'h81);
      r = put8(r, ext | {5'd0, dest});
    end
    r = put32(r, v);
    return r;
  endfunction

  function automatic x86enc_pkg::enc_t jcc(x86enc_pkg::enc_t e, logic [7:0] op,
                                           logic [63:0] v);
    x86enc_pkg::enc_t r;
    r = put8(e, 8'h0f);
    r = put8(r, op);
    r = put32(r, v);
    return r;
  endfunction

  logic             f8;
  logic [63:0]      slot;
  x86enc_pkg::enc_t e0;

  // 8-bit form when the low word sign-extends from its low byte
  assign f8   = (immediate[31:7] == '0) || (immediate[31:7] == '1);
  assign slot = 64'd8;
  assign e0   = '0;

  // per-operation byte assembly
  always_comb begin
    enc = e0;
    case (cmd)
      x86enc_pkg::CMD_PUSH:      enc = put8(e0, 8'h50 | {5'd0, first_reg});
      x86enc_pkg::CMD_PUSH_F:    enc = st_float(alu_byte(e0, 8'he8, x86enc_pkg::RegSp, slot,
                                   1'b0), x86enc_pkg::RegSp, 64'd0, first_reg, 1'b0);
      x86enc_pkg::CMD_PUSH_IMM:  enc = put32(put8(e0, 8'h68), immediate);
      x86enc_pkg::CMD_POP:       enc = put8(e0, 8'h58 | {5'd0, first_reg});
      x86enc_pkg::CMD_POP_NUM:   enc = put8(put8(e0, 8'h41), 8'h58 | {5'd0, first_reg});
      x86enc_pkg::CMD_POP_F:     enc = alu_byte(ld_float(e0, first_reg, x86enc_pkg::RegSp),
                                   8'hc0, x86enc_pkg::RegSp, slot, 1'b0);
      x86enc_pkg::CMD_MOV_RR:    enc = put8(put8(put8(e0, 8'h48), 8'h89),
                                   {2'b11, second_reg, first_reg});
      x86enc_pkg::CMD_MOV_RR_ND: enc = put8(put8(put8(e0, 8'h49), 8'h89),
                                   {2'b11, second_reg, first_reg});
      x86enc_pkg::CMD_MOV_RR_NS: enc = put8(put8(put8(e0, 8'h4c), 8'h89),
                                   {2'b11, second_reg, first_reg});
      x86enc_pkg::CMD_MOV_ABS_ST: enc = put64(put8(put8(e0, 8'h48), 8'ha3), immediate);
      x86enc_pkg::CMD_MOV_ABS_LD: enc = put64(put8(put8(e0, 8'h48), 8'ha1), immediate);
      x86enc_pkg::CMD_LD_IND:    enc = put8(put8(wide(e0, narrow), 8'h8b),
                                   {2'b00, first_reg, second_reg});
      x86enc_pkg::CMD_ST_AUTO:   enc = f8 ?
                                   st_char_gp(e0, first_reg, immediate, second_reg, narrow) :
                                   st_int_any(e0, 8'h48, !narrow, first_reg, immediate,
                                              second_reg);
      x86enc_pkg::CMD_ST_AUTO_NUM: enc = f8 ?
                                   st_char_num(e0, first_reg, immediate, second_reg) :
                                   st_int_any(e0, 8'h4c, 1'b1, first_reg, immediate,
                                              second_reg);
      x86enc_pkg::CMD_ST8:       enc = st_char_gp(e0, first_reg, immediate, second_reg, narrow);
      x86enc_pkg::CMD_ST8_NUM:   enc = st_char_num(e0, first_reg, immediate, second_reg);
      x86enc_pkg::CMD_ST32:      enc = st_int_any(e0, 8'h48, !narrow, first_reg, immediate,
                                   second_reg);
      x86enc_pkg::CMD_ST32_NUM:  enc = st_int_any(e0, 8'h4c, 1'b1, first_reg, immediate,
                                   second_reg);
      x86enc_pkg::CMD_LD_AUTO:   enc = ld_off(e0, first_reg, second_reg, immediate, !f8);
      x86enc_pkg::CMD_LD8:       enc = ld_off(e0, first_reg, second_reg, immediate, 1'b0);
      x86enc_pkg::CMD_LD32:      enc = ld_off(e0, first_reg, second_reg, immediate, 1'b1);
      x86enc_pkg::CMD_MOV_IMM:   enc = put32(put8(put8(put8(e0, 8'h48), 8'hc7),
                                   8'hc0 | {5'd0, first_reg}), immediate);
      x86enc_pkg::CMD_MOV_IMM_NUM: enc = put32(put8(put8(put8(e0, 8'h49), 8'hc7),
                                   8'hc0 | {5'd0, first_reg}), immediate);
      x86enc_pkg::CMD_MOV_IMM64: enc = put64(put8(put8(e0, 8'h48),
                                   8'hb8 | {5'd0, first_reg}), immediate);
      x86enc_pkg::CMD_MOV_IMM64_NUM: enc = put64(put8(put8(e0, 8'h49),
                                   8'hb8 | {5'd0, first_reg}), immediate);
      x86enc_pkg::CMD_LD_F:      enc = ld_float(e0, first_reg, second_reg);
      x86enc_pkg::CMD_ST_F_AUTO: enc = st_float(e0, first_reg, immediate, second_reg, !f8);
      x86enc_pkg::CMD_ST_F8:     enc = st_float(e0, first_reg, immediate, second_reg, 1'b0);
      x86enc_pkg::CMD_ST_F32:    enc = st_float(e0, first_reg, immediate, second_reg, 1'b1);
      x86enc_pkg::CMD_CALL_REG:  enc = put8(put8(e0, 8'hff), 8'hd0 | {5'd0, first_reg});
      x86enc_pkg::CMD_CALL:      enc = put32(put8(e0, 8'he8), immediate);
      x86enc_pkg::CMD_RET:       enc = put8(e0, 8'hc3);
      x86enc_pkg::CMD_ADD_RR:    enc = reg_reg(e0, narrow, 8'h01, first_reg, second_reg);
      x86enc_pkg::CMD_ADD_AUTO:  enc = f8 ? alu_byte(e0, 8'hc0, first_reg, immediate, narrow) :
                                   alu_int(e0, 8'hc0, 8'h05, first_reg, immediate, narrow);
      x86enc_pkg::CMD_ADD8:      enc = alu_byte(e0, 8'hc0, first_reg, immediate, narrow);
      x86enc_pkg::CMD_ADD32:     enc = alu_int(e0, 8'hc0, 8'h05, first_reg, immediate, narrow);
      x86enc_pkg::CMD_SUB_RR:    enc = reg_reg(e0, narrow, 8'h29, first_reg, second_reg);
      x86enc_pkg::CMD_SUB8:      enc = alu_byte(e0, 8'he8, first_reg, immediate, narrow);
      x86enc_pkg::CMD_SUB32:     enc = alu_int(e0, 8'he8, 8'h2d, first_reg, immediate, narrow);
      x86enc_pkg::CMD_IMUL:      enc = put8(put8(put8(wide(e0, narrow), 8'h0f), 8'haf),
                                   {2'b11, first_reg, second_reg});
      x86enc_pkg::CMD_IDIV:      enc = put8(put8(wide(e0, narrow), 8'hf7),
                                   8'hf8 | {2'b00, first_reg, second_reg});
      x86enc_pkg::CMD_AND:       enc = reg_reg(e0, narrow, 8'h21, first_reg, second_reg);
      x86enc_pkg::CMD_OR:        enc = reg_reg(e0, narrow, 8'h09, first_reg, second_reg);
      x86enc_pkg::CMD_XOR:       enc = reg_reg(e0, narrow, 8'h31, first_reg, second_reg);
      x86enc_pkg::CMD_NOT:       enc = put8(put8(wide(e0, narrow), 8'hf7),
                                   8'hd0 | {5'd0, first_reg});
      x86enc_pkg::CMD_CMP:       enc = reg_reg(e0, 1'b0, 8'h39, first_reg, second_reg);
      x86enc_pkg::CMD_JMP:       enc = put32(put8(e0, 8'he9), immediate);
      x86enc_pkg::CMD_JE:        enc = jcc(e0, 8'h84, immediate);
      x86enc_pkg::CMD_JNE:       enc = jcc(e0, 8'h85, immediate);
      x86enc_pkg::CMD_JG:        enc = jcc(e0, 8'h8f, immediate);
      x86enc_pkg::CMD_JA:        enc = jcc(e0, 8'h87, immediate);
      x86enc_pkg::CMD_JGE:       enc = jcc(e0, 8'h8d, immediate);
      x86enc_pkg::CMD_JAE:       enc = jcc(e0, 8'h83, immediate);
      x86enc_pkg::CMD_JL:        enc = jcc(e0, 8'h8c, immediate);
      x86enc_pkg::CMD_JB:        enc = jcc(e0, 8'h82, immediate);
      x86enc_pkg::CMD_JLE:       enc = jcc(e0, 8'h8e, immediate);
      x86enc_pkg::CMD_JBE:       enc = jcc(e0, 8'h86, immediate);
      default:                   enc = e0;
    endcase
  end

endmodule

// ===== design/x86_64_instruction_encoder.sv =====
// x86_64_instruction_encoder: top level, request register, encoder, byte buffer
// depends on x86enc_pkg, x86enc_if and x86enc_encode
//
// Usage: the req channel takes one instruction request (cmd, first_reg,
// second_reg, narrow, immediate) per handshake. The code channel returns the
// machine code of that request one byte per handshake, in order, with last
// set on its final byte. Unused cmd codes produce no bytes at all.
// Flow: an accepted request passes the request register, then the byte buffer,
// which shows its first byte. The code channel gives one byte per cycle while
// the receiver is ready, up to 10 bytes per request; the byte buffer reloads in
// the cycle its last byte is taken, so the next instruction's bytes follow
// without a gap when it already waits in the request register. A request with
// no bytes only passes the request register and leaves the byte buffer empty.
// Reset (rst, synchronous) empties the request register and the byte buffer;
// no byte is pending afterwards. When the receiver stalls, the current byte
// holds, the request register fills and req.ready drops until the buffer
// frees up.

module x86_64_instruction_encoder (
  input  logic           clk,
  input  logic           rst,
  x86enc_req_if.sink     req,
  x86enc_code_if.source  code
);

  logic                             a_valid;
  logic [5:0]                       a_cmd;
  logic [2:0]                       a_first;
  logic [2:0]                       a_second;
  logic                             a_narrow;
  logic [63:0]                      a_imm;
  x86enc_pkg::enc_t                 enc;
  logic                             b_valid;
  logic [x86enc_pkg::MaxBytes-1:0][7:0] buf_bytes;
  x86enc_pkg::count_t               buf_count;
  x86enc_pkg::idx_t                 idx;
  logic                             is_last;
  logic                             b_free;
  logic                             load;

  assign is_last = (idx == buf_count - 4'd1);
  assign b_free  = !b_valid || (code.ready && is_last);
  assign load    = a_valid && b_free;
  assign req.ready = !a_valid || b_free;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_cmd    <= req.cmd;
      a_first  <= req.first_reg;
      a_second <= req.second_reg;
      a_narrow <= req.narrow;
      a_imm    <= req.immediate;
    end
  end

  x86enc_encode u_encode (
    .cmd        (a_cmd),
    .first_reg  (a_first),
    .second_reg (a_second),
    .narrow     (a_narrow),
    .immediate  (a_imm),
    .enc        (enc)
  );

  // byte buffer and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      b_valid <= (enc.count != '0);
      idx     <= '0;
    end else if (b_free) begin
      b_valid <= 1'b0;
    end else if (code.ready) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= enc.bytes;
      buf_count <= enc.count;
    end
  end

  assign code.valid     = b_valid;
  assign code.code_byte = buf_bytes[idx];
  assign code.last      = is_last;

endmodule

// ===== verif/tb_x86_64_instruction_encoder.sv =====
// tb_x86_64_instruction_encoder: self-checking bench for the instruction encoder
// depends on x86enc_pkg, x86enc_if and the encoder top level

module tb_x86_64_instruction_encoder;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;

  x86enc_req_if  req ();
  x86enc_code_if code ();

  x86_64_instruction_encoder u_top (
    .clk  (clk),
    .rst  (rst),
    .req  (req.sink),
    .code (code.source)
  );

  always #1 clk = ~clk;

  // expected code bytes with their last flag, oldest first
  logic [8:0] code_queue[$];

  // encoding buffer for one instruction
  logic [7:0] enc_buf[$];

  function automatic void emit(input logic [7:0] b);
    if (enc_buf.size() < x86enc_pkg::MaxBytes) enc_buf.insert(enc_buf.size(), b);
  endfunction

  function automatic void emit32(input logic [63:0] v);
    for (int i = 0; i < 4; i++) emit(v[8*i +: 8]);
  endfunction

  function automatic void emit64(input logic [63:0] v);
    for (int i = 0; i < 8; i++) emit(v[8*i +: 8]);
  endfunction

  function automatic void emit_rex(input logic nr);
    if (!nr) emit(8'h48);
  endfunction

  // store of a general register at base+offset, 8-bit offset form
  function automatic void enc_st8(input logic [2:0] base, input logic [63:0] off,
                                  input logic [2:0] src, input logic nr);
    emit_rex(nr);
    emit(8'h89);
    if (base != x86enc_pkg::RegSp) emit({2'b01, src, base});
    else begin
      emit({2'b01, src, 3'b100});
      emit(8'h24);
    end
    emit(off[7:0]);
  endfunction

  function automatic void enc_st8_num(input logic [2:0] base, input logic [63:0] off,
                                      input logic [2:0] src);
    emit(8'h4c);
    emit(8'h89);
    emit({2'b01, src, base});
    emit(off[7:0]);
  endfunction

  function automatic void enc_st32(input logic [7:0] pre, input logic use_pre,
                                   input logic [2:0] base, input logic [63:0] off,
                                   input logic [2:0] src);
    if (use_pre) emit(pre);
    emit(8'h89);
    if (base != x86enc_pkg::RegSp) emit({2'b10, src, base});
    else begin
      emit({2'b10, src, 3'b100});
      emit(8'h24);
    end
    emit32(off);
  endfunction

  function automatic void enc_ld(input logic [2:0] dest, input logic [2:0] base,
                                 input logic [63:0] off, input logic is32);
    logic [1:0] md;
    md = is32 ? 2'b10 : 2'b01;
    emit(8'h48);
    emit(8'h8b);
    if (base != x86enc_pkg::RegSp) emit({md, dest, base});
    else begin
      emit({md, dest, 3'b100});
      emit(8'h24);
    end
    if (is32) emit32(off); else emit(off[7:0]);
  endfunction

  function automatic void enc_ld_f(input logic [2:0] dest, input logic [2:0] base);
    emit(8'hf3); emit(8'h0f); emit(8'h10);
    if (base == x86enc_pkg::RegSp) begin
      emit({2'b00, dest, 3'b100});
      emit(8'h24);
    end else if (base == x86enc_pkg::RegBp) begin
      emit({2'b01, dest, 3'b101});
      emit(8'h00);
    end else emit({2'b00, dest, base});
  endfunction

  function automatic void enc_st_f(input logic [2:0] base, input logic [63:0] off,
                                   input logic [2:0] src, input logic is32);
    logic [1:0] md;
    md = is32 ? 2'b10 : 2'b01;
    emit(8'hf3); emit(8'h0f); emit(8'h11);
    if (base != x86enc_pkg::RegSp) emit({md, src, base});
    else begin
      emit({md, src, 3'b100});
      emit(8'h24);
    end
    if (is32) emit32(off); else emit(off[7:0]);
  endfunction

  function automatic void enc_alu8(input logic [7:0] ext, input logic [2:0] dest,
                                   input logic [63:0] v, input logic nr);
    emit_rex(nr);
    emit(8'h83);
    emit(ext | {5'd0, dest});
    emit(v[7:0]);
  endfunction

  function automatic void enc_alu32(input logic [7:0] ext, input logic [7:0] short_op,
                                    input logic [2:0] dest, input logic [63:0] v,
                                    input logic nr);
    emit_rex(nr);
    if (dest == x86enc_pkg::RegAx) emit(short_op);
    else begin
      emit(8'h81);
      emit(ext | {5'd0, dest});
    end
    emit32(v);
  endfunction

  function automatic void enc_rr(input logic nr, input logic [7:0] op,
                                 input logic [2:0] rm, input logic [2:0] rg);
    emit_rex(nr);
    emit(op);
    emit({2'b11, rg, rm});
  endfunction

  function automatic void enc_jcc(input logic [7:0] op, input logic [63:0] v);
    emit(8'h0f);
    emit(op);
    emit32(v);
  endfunction

  // work out the code bytes of one request and queue them
  function automatic void predict_code(input x86enc_pkg::cmd_t c, input logic [2:0] a,
                                       input logic [2:0] b, input logic nr,
                                       input logic [63:0] imm);
    logic f8;
    logic [31:0] lo;
    lo = imm[31:0] + 32'd128;
    f8 = lo < 32'd256;
    enc_buf.delete();
    case (c)
      x86enc_pkg::CMD_PUSH:     emit(8'h50 | {5'd0, a});
      x86enc_pkg::CMD_PUSH_F: begin
        enc_alu8(8'he8, x86enc_pkg::RegSp, 64'd8, 1'b0);
        enc_st_f(x86enc_pkg::RegSp, 64'd0, a, 1'b0);
      end
      x86enc_pkg::CMD_PUSH_IMM: begin emit(8'h68); emit32(imm); end
      x86enc_pkg::CMD_POP:      emit(8'h58 | {5'd0, a});
      x86enc_pkg::CMD_POP_NUM: begin emit(8'h41); emit(8'h58 | {5'd0, a}); end
      x86enc_pkg::CMD_POP_F: begin
        enc_ld_f(a, x86enc_pkg::RegSp);
        enc_alu8(8'hc0, x86enc_pkg::RegSp, 64'd8, 1'b0);
      end
      x86enc_pkg::CMD_MOV_RR: begin
        emit(8'h48); emit(8'h89); emit({2'b11, b, a});
      end
      x86enc_pkg::CMD_MOV_RR_ND: begin
        emit(8'h49); emit(8'h89); emit({2'b11, b, a});
      end
      x86enc_pkg::CMD_MOV_RR_NS: begin
        emit(8'h4c); emit(8'h89); emit({2'b11, b, a});
      end
      x86enc_pkg::CMD_MOV_ABS_ST: begin emit(8'h48); emit(8'ha3); emit64(imm); end
      x86enc_pkg::CMD_MOV_ABS_LD: begin emit(8'h48); emit(8'ha1); emit64(imm); end
      x86enc_pkg::CMD_LD_IND: begin emit_rex(nr); emit(8'h8b); emit({2'b00, a, b}); end
      x86enc_pkg::CMD_ST_AUTO:
        if (f8) enc_st8(a, imm, b, nr); else enc_st32(8'h48, !nr, a, imm, b);
      x86enc_pkg::CMD_ST_AUTO_NUM:
        if (f8) enc_st8_num(a, imm, b); else enc_st32(8'h4c, 1'b1, a, imm, b);
      x86enc_pkg::CMD_ST8:       enc_st8(a, imm, b, nr);
      x86enc_pkg::CMD_ST8_NUM:   enc_st8_num(a, imm, b);
      x86enc_pkg::CMD_ST32:      enc_st32(8'h48, !nr, a, imm, b);
      x86enc_pkg::CMD_ST32_NUM:  enc_st32(8'h4c, 1'b1, a, imm, b);
      x86enc_pkg::CMD_LD_AUTO:   enc_ld(a, b, imm, !f8);
      x86enc_pkg::CMD_LD8:       enc_ld(a, b, imm, 1'b0);
      x86enc_pkg::CMD_LD32:      enc_ld(a, b, imm, 1'b1);
      x86enc_pkg::CMD_MOV_IMM: begin
        emit(8'h48); emit(8'hc7); emit(8'hc0 | {5'd0, a}); emit32(imm);
      end
      x86enc_pkg::CMD_MOV_IMM_NUM: begin
        emit(8'h49); emit(8'hc7); emit(8'hc0 | {5'd0, a}); emit32(imm);
      end
      x86enc_pkg::CMD_MOV_IMM64: begin
        emit(8'h48); emit(8'hb8 | {5'd0, a}); emit64(imm);
      end
      x86enc_pkg::CMD_MOV_IMM64_NUM: begin
        emit(8'h49); emit(8'hb8 | {5'd0, a}); emit64(imm);
      end
      x86enc_pkg::CMD_LD_F:      enc_ld_f(a, b);
      x86enc_pkg::CMD_ST_F_AUTO: enc_st_f(a, imm, b, !f8);
      x86enc_pkg::CMD_ST_F8:     enc_st_f(a, imm, b, 1'b0);
      x86enc_pkg::CMD_ST_F32:    enc_st_f(a, imm, b, 1'b1);
      x86enc_pkg::CMD_CALL_REG: begin emit(8'hff); emit(8'hd0 | {5'd0, a}); end
      x86enc_pkg::CMD_CALL:     begin emit(8'he8); emit32(imm); end
      x86enc_pkg::CMD_RET:      emit(8'hc3);
      x86enc_pkg::CMD_ADD_RR:   enc_rr(nr, 8'h01, a, b);
      x86enc_pkg::CMD_ADD_AUTO:
        if (f8) enc_alu8(8'hc0, a, imm, nr); else enc_alu32(8'hc0, 8'h05, a, imm, nr);
      x86enc_pkg::CMD_ADD8:     enc_alu8(8'hc0, a, imm, nr);
      x86enc_pkg::CMD_ADD32:    enc_alu32(8'hc0, 8'h05, a, imm, nr);
      x86enc_pkg::CMD_SUB_RR:   enc_rr(nr, 8'h29, a, b);
      x86enc_pkg::CMD_SUB8:     enc_alu8(8'he8, a, imm, nr);
      x86enc_pkg::CMD_SUB32:    enc_alu32(8'he8, 8'h2d, a, imm, nr);
      x86enc_pkg::CMD_IMUL: begin
        emit_rex(nr); emit(8'h0f); emit(8'haf); emit({2'b11, a, b});
      end
      x86enc_pkg::CMD_IDIV: begin
        emit_rex(nr); emit(8'hf7); emit(8'hf8 | {2'b00, a, b});
      end
      x86enc_pkg::CMD_AND:      enc_rr(nr, 8'h21, a, b);
      x86enc_pkg::CMD_OR:       enc_rr(nr, 8'h09, a, b);
      x86enc_pkg::CMD_XOR:      enc_rr(nr, 8'h31, a, b);
      x86enc_pkg::CMD_NOT: begin
        emit_rex(nr); emit(8'hf7); emit(8'hd0 | {5'd0, a});
      end
      x86enc_pkg::CMD_CMP:      enc_rr(1'b0, 8'h39, a, b);
      x86enc_pkg::CMD_JMP: begin emit(8'he9); emit32(imm); end
      x86enc_pkg::CMD_JE:       enc_jcc(8'h84, imm);
      x86enc_pkg::CMD_JNE:      enc_jcc(8'h85, imm);
      x86enc_pkg::CMD_JG:       enc_jcc(8'h8f, imm);
      x86enc_pkg::CMD_JA:       enc_jcc(8'h87, imm);
      x86enc_pkg::CMD_JGE:      enc_jcc(8'h8d, imm);
      x86enc_pkg::CMD_JAE:      enc_jcc(8'h83, imm);
      x86enc_pkg::CMD_JL:       enc_jcc(8'h8c, imm);
      x86enc_pkg::CMD_JB:       enc_jcc(8'h82, imm);
      x86enc_pkg::CMD_JLE:      enc_jcc(8'h8e, imm);
      x86enc_pkg::CMD_JBE:      enc_jcc(8'h86, imm);
      default: ;
    endcase
    for (int i = 0; i < enc_buf.size(); i++)
      code_queue.insert(code_queue.size(), {enc_buf[i], i == enc_buf.size() - 1});
  endfunction

  // send one request, with random idle cycles before it
  task automatic send_req(input x86enc_pkg::cmd_t c, input logic [2:0] a,
                          input logic [2:0] b, input logic nr, input logic [63:0] imm);
    while ($urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.cmd        <= c;
    req.first_reg  <= a;
    req.second_reg <= b;
    req.narrow     <= nr;
    req.immediate  <= imm;
    do @(posedge clk); while (!req.ready);
    predict_code(c, a, b, nr, imm);
    @(negedge clk);
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    if (rst) code.ready <= 1'b0;
    else code.ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // compare each code byte with the oldest expectation
  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst && code.valid && code.ready) begin
      if (code_queue.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, code.code_byte, code.last);
        errors++;
      end else begin
        want = code_queue.pop_front();
        if (code.code_byte !== want[8:1]) begin
          $display("%0t: code_byte expected %h actual %h", $time, want[8:1], code.code_byte);
          errors++;
        end
        if (code.last !== want[0]) begin
          $display("%0t: last expected %b actual %b", $time, want[0], code.last);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_imm();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = {{56{v[7]}}, v[7:0]};
      1: v = {{32{v[31]}}, v[31:0]};
      2: v[31:0] = $urandom_range(300) - 150;
      default: ;
    endcase
    return v;
  endfunction

  // auto-sized forms at boundary offsets, then single forms with extreme registers
  task automatic test_directed();
    logic [63:0] edges[6];
    edges = '{64'h7fffffffffffffff, 64'h8000000000000000, 64'd127,
              64'hffffffffffffff80, 64'd128, 64'hffffffffffffff7f};
    for (int k = 0; k < 6; k++) begin
      send_req(x86enc_pkg::CMD_ST_AUTO, x86enc_pkg::RegSp, 3'd7, k[0], edges[k]);
      send_req(x86enc_pkg::CMD_ADD_AUTO, x86enc_pkg::RegAx, 3'd0, k[0], edges[k]);
      send_req(x86enc_pkg::CMD_LD_AUTO, 3'd7, x86enc_pkg::RegSp, 1'b0, edges[k]);
    end
    send_req(x86enc_pkg::CMD_LD_IND, 3'd7, x86enc_pkg::RegBp, 1'b1, 64'd0);
    send_req(x86enc_pkg::CMD_LD_F, 3'd7, x86enc_pkg::RegBp, 1'b0, 64'd0);
    send_req(x86enc_pkg::CMD_ST8_NUM, x86enc_pkg::RegSp, 3'd7, 1'b0, 64'h5a);
    send_req(x86enc_pkg::CMD_IDIV, 3'd7, 3'd7, 1'b0, 64'd0);
    send_req(x86enc_pkg::cmd_t'(6'd63), 3'd7, 3'd7, 1'b1, '1);
    send_req(x86enc_pkg::CMD_MOV_ABS_ST, 3'd7, 3'd0, 1'b0, 64'h0123456789abcdef);
  endtask

  task automatic test_all_forms();
    for (int c = 0; c < 64; c++)
      send_req(x86enc_pkg::cmd_t'(c), 3'($urandom), 3'($urandom), 1'($urandom),
               rand_imm());
  endtask

  task automatic test_random(input int n, input int sgap, input int rgap);
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    for (int i = 0; i < n; i++)
      send_req(x86enc_pkg::cmd_t'($urandom_range(i % 16 == 0 ? 63 : 56)), 3'($urandom),
               3'($urandom), 1'($urandom), rand_imm());
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = '0;
    req.first_reg = '0;
    req.second_reg = '0;
    req.narrow = 1'b0;
    req.immediate = '0;
    code.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_gap_pct = 8;
    recv_gap_pct = 53;
    test_directed();
    test_all_forms();
    test_random(70, 8, 53);
    test_random(70, 53, 8);
    test_random(70, 0, 0);
    req.valid <= 1'b0;
    while (code_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
